// ----- sv/rsa_pkg.sv -----
`default_nettype none

package rsa_pkg;

  // signed 32-bit range for the square term
  localparam logic signed [63:0] SQ_RANGE_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SQ_RANGE_MIN = -64'sd2147483648;

  localparam int CountW = 63;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_MERGE  = 1'b1
  } rsa_cmd_t;

  // first field in the lowest bits: members listed from the top down
  typedef struct packed {
    logic signed [63:0] other_sum_squares;
    logic signed [63:0] other_sum;
    logic signed [63:0] other_max;
    logic signed [63:0] other_min_nonzero;
    logic [CountW-1:0]  other_count;
    logic signed [63:0] sample;
  } rsa_in_data_t;

  typedef struct packed {
    rsa_cmd_t     command;
    rsa_in_data_t data;
  } rsa_item_t;

  typedef struct packed {
    logic signed [63:0] greatest_value;
    logic signed [63:0] least_value;
    logic signed [63:0] least_nonzero;
    logic signed [63:0] total_sum_squares;
    logic signed [63:0] total_sum;
    logic [CountW-1:0]  total_count;
  } rsa_out_data_t;

  typedef struct packed {
    logic          square_skipped;
    rsa_out_data_t data;
  } rsa_result_t;

  localparam int InDataW  = $bits(rsa_in_data_t);
  localparam int OutDataW = $bits(rsa_out_data_t);
  localparam int InTdataW  = ((InDataW + 7) / 8) * 8;
  localparam int OutTdataW = ((OutDataW + 7) / 8) * 8;

endpackage

`default_nettype wire

// ----- sv/rsa_in_stage.sv -----
`default_nettype none

module rsa_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rsa_pkg::rsa_item_t in_item,
  input  wire logic               advance,
  output logic                    valid,
  output rsa_pkg::rsa_item_t      item
);

  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/rsa_core.sv -----
`default_nettype none

module rsa_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire rsa_pkg::rsa_item_t item,
  output rsa_pkg::rsa_result_t    result
);

  logic [63:0]        count;
  logic [63:0]        sum;
  logic [63:0]        sum_squares;
  logic signed [63:0] min_nonzero;
  logic signed [63:0] min_any;
  logic signed [63:0] max;

  logic [63:0]        count_next;
  logic [63:0]        sum_next;
  logic [63:0]        sum_squares_next;
  logic signed [63:0] min_nonzero_next;
  logic signed [63:0] min_any_next;
  logic signed [63:0] max_next;
  logic               skipped;

  logic signed [63:0] v;
  logic signed [31:0] v32;
  logic signed [63:0] square;
  logic               first;
  logic               fits;
  logic signed [63:0] nz_base;
  logic signed [63:0] any_base;
  logic signed [63:0] max_base;

  assign v      = item.data.sample;
  assign v32    = v[31:0];
  assign square = 64'(v32) * 64'(v32);
  assign fits   = (v <= rsa_pkg::SQ_RANGE_MAX) && (v >= rsa_pkg::SQ_RANGE_MIN);
  // count becomes one on this record
  assign first  = (count == 64'd0);

  always_comb begin
    count_next       = count;
    sum_next         = sum;
    sum_squares_next = sum_squares;
    min_nonzero_next = min_nonzero;
    min_any_next     = min_any;
    max_next         = max;
    skipped          = 1'b0;
    nz_base          = first ? v : min_nonzero;
    any_base         = first ? v : min_any;
    max_base         = first ? v : max;
    case (item.command)
      rsa_pkg::CMD_RECORD: begin
        count_next       = count + 64'd1;
        sum_next         = sum + v;
        min_nonzero_next = nz_base;
        if (v != 64'sd0 && (nz_base == 64'sd0 || v < nz_base)) begin
          min_nonzero_next = v;
        end
        min_any_next = (v < any_base) ? v : any_base;
        max_next     = (max_base < v) ? v : max_base;
        if (fits) begin
          sum_squares_next = sum_squares + square;
        end else begin
          skipped = 1'b1;
        end
      end
      rsa_pkg::CMD_MERGE: begin
        count_next = count + {1'b0, item.data.other_count};
        if (item.data.other_min_nonzero != 64'sd0 &&
            item.data.other_min_nonzero < min_nonzero) begin
          min_nonzero_next = item.data.other_min_nonzero;
        end
        if (max < item.data.other_max) begin
          max_next = item.data.other_max;
        end
        sum_next         = sum + item.data.other_sum;
        sum_squares_next = sum_squares + item.data.other_sum_squares;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      sum         <= '0;
      sum_squares <= '0;
      min_nonzero <= '0;
      min_any     <= '0;
      max         <= '0;
    end else if (step) begin
      count       <= count_next;
      sum         <= sum_next;
      sum_squares <= sum_squares_next;
      min_nonzero <= min_nonzero_next;
      min_any     <= min_any_next;
      max         <= max_next;
    end
  end

  always_comb begin
    result.square_skipped         = skipped;
    result.data.total_count       = count_next[rsa_pkg::CountW-1:0];
    result.data.total_sum         = sum_next;
    result.data.total_sum_squares = sum_squares_next;
    result.data.least_nonzero     = min_nonzero_next;
    result.data.least_value       = min_any_next;
    result.data.greatest_value    = max_next;
  end

endmodule

`default_nettype wire

// ----- sv/rsa_out_stage.sv -----
`default_nettype none

module rsa_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire rsa_pkg::rsa_result_t load_result,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rsa_pkg::rsa_result_t      result
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      result <= load_result;
    end
  end

endmodule

`default_nettype wire

// ----- sv/running_stats_accumulator.sv -----
`default_nettype none

// Running statistics over signed 64-bit samples. Each transfer on the slave side
// either records one sample (tuser command 0) or merges another accumulator's
// totals (command 1), and each produces exactly one result transfer carrying the
// count, wrapping sum, wrapping sum of squares, nonzero minimum, true minimum and
// maximum as they stand after that item. The first recorded sample loads both
// minimums and the maximum; samples outside the signed 32-bit range add nothing
// to the sum of squares and set the square_skipped flag. Each item is held in the
// input register until the result slot is free, then moves into the accumulators
// and the result register together. The block takes one item every cycle while
// the master side accepts results: the accumulator registers and the result
// register load at the same edge, behind one 32x32 multiply plus a 64-bit add.
// The result register lets the next item be taken while a result waits.
// All statistics are zero after reset.

module running_stats_accumulator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // sample, other_count, other_min_nonzero, other_max, other_sum,
  // other_sum_squares, zero pad
  input  wire logic [rsa_pkg::InTdataW-1:0]    s_tdata,
  // command
  input  wire logic [0:0]                      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // total_count, total_sum, total_sum_squares, least_nonzero, least_value,
  // greatest_value, zero pad
  output logic [rsa_pkg::OutTdataW-1:0]        m_tdata,
  // square_skipped
  output logic [0:0]                           m_tuser
);

  localparam int OutPadW = rsa_pkg::OutTdataW - rsa_pkg::OutDataW;

  rsa_pkg::rsa_item_t   s_item;
  rsa_pkg::rsa_item_t   stage_item;
  rsa_pkg::rsa_result_t core_result;
  rsa_pkg::rsa_result_t out_result;
  logic                 stage_valid;
  logic                 advance;

  // unpack the slave transfer
  assign s_item.command = rsa_pkg::rsa_cmd_t'(s_tuser[0]);
  assign s_item.data    = s_tdata[rsa_pkg::InDataW-1:0];

  // the registered item moves into the accumulators when the result slot frees
  assign advance = stage_valid && (!m_tvalid || m_tready);

  rsa_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (s_item),
    .advance  (advance),
    .valid    (stage_valid),
    .item     (stage_item)
  );

  // accumulator state and the update for one item
  rsa_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (stage_item),
    .result (core_result)
  );

  // result register toward the master side
  rsa_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance),
    .load_result (core_result),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (out_result)
  );

  assign m_tdata    = {{OutPadW{1'b0}}, out_result.data};
  assign m_tuser[0] = out_result.square_skipped;

endmodule

`default_nettype wire

// ----- sv/rsa_checker.sv -----
`default_nettype none

module rsa_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         s_tvalid,
  input wire logic                         s_tready,
  input wire logic                         m_tvalid,
  input wire logic                         m_tready,
  input wire logic [rsa_pkg::OutTdataW-1:0] m_tdata,
  input wire logic [0:0]                   m_tuser
);

  rsa_pkg::rsa_out_data_t d;

  assign d = m_tdata[rsa_pkg::OutDataW-1:0];

  // no result is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // the true minimum never exceeds the maximum
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> d.least_value <= d.greatest_value)
    else $error("least value above greatest value");

  // a skipped square means an out of range sample left its mark on min or max
  a_skip_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |->
      d.greatest_value > rsa_pkg::SQ_RANGE_MAX || d.least_value < rsa_pkg::SQ_RANGE_MIN)
    else $error("square skipped for an in range sample");

  // an input transfer taken while a result stalls fills the input slot, so the
  // slave side stays closed until the master side moves
  a_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tvalid && !m_tready |=> m_tready || !s_tready)
    else $error("input taken with no room");

endmodule

bind running_stats_accumulator rsa_checker u_rsa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- tb/running_stats_accumulator_tb.sv -----
module running_stats_accumulator_tb;
  import rsa_pkg::*;

  localparam logic [63:0] MAX63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] INT64_MIN = 64'sh8000_0000_0000_0000;
  localparam int CYCLE_LIMIT = 500000;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // sample, other_count, other_min_nonzero, other_max, other_sum,
  // other_sum_squares, zero pad
  logic [InTdataW-1:0]  s_tdata;
  // command
  logic [0:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  // total_count, total_sum, total_sum_squares, least_nonzero, least_value,
  // greatest_value, zero pad
  logic [OutTdataW-1:0] m_tdata;
  // square_skipped
  logic [0:0]           m_tuser;

  // running totals as the block should hold them after each accepted transfer
  logic [63:0]        stat_count;
  logic signed [63:0] stat_sum;
  logic signed [63:0] stat_sumsq;
  logic signed [63:0] stat_min_nz;
  logic signed [63:0] stat_min;
  logic signed [63:0] stat_max;

  rsa_result_t pending_totals[$];

  int errors;
  int cycle_count;
  int n_records;
  int n_merges;
  int n_checked;
  int n_skipped;
  bit steady;

  running_stats_accumulator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               pending_totals.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch #%0d on %s: got %h, expected %h", n_checked, what, got, want);
    errors++;
  endtask

  // advance the predicted totals by one item and return the result it causes
  function automatic rsa_result_t fold_into_totals(rsa_item_t it);
    rsa_result_t r;
    logic signed [63:0] v;
    logic signed [63:0] omin;
    v = it.data.sample;
    r.square_skipped = 1'b0;
    if (it.command == CMD_RECORD) begin
      stat_count = stat_count + 64'd1;
      stat_sum = stat_sum + v;
      // first sample loads both minimums and the maximum
      if (stat_count == 64'd1) begin
        stat_min_nz = v;
        stat_min = v;
        stat_max = v;
      end
      if (v != 0 && (stat_min_nz == 0 || v < stat_min_nz)) stat_min_nz = v;
      if (v < stat_min) stat_min = v;
      if (v > stat_max) stat_max = v;
      if (v <= SQ_RANGE_MAX && v >= SQ_RANGE_MIN) stat_sumsq = stat_sumsq + v * v;
      else r.square_skipped = 1'b1;
    end else begin
      omin = it.data.other_min_nonzero;
      stat_count = stat_count + {1'b0, it.data.other_count};
      // a zero register is never filled by a positive merged minimum
      if (omin != 0 && omin < stat_min_nz) stat_min_nz = omin;
      if (it.data.other_max > stat_max) stat_max = it.data.other_max;
      stat_sum = stat_sum + it.data.other_sum;
      stat_sumsq = stat_sumsq + it.data.other_sum_squares;
    end
    r.data.total_count = stat_count[CountW-1:0];
    r.data.total_sum = stat_sum;
    r.data.total_sum_squares = stat_sumsq;
    r.data.least_nonzero = stat_min_nz;
    r.data.least_value = stat_min;
    r.data.greatest_value = stat_max;
    return r;
  endfunction

  function automatic rsa_item_t record_item(logic signed [63:0] v);
    rsa_item_t it;
    it = '0;
    it.command = CMD_RECORD;
    it.data.sample = v;
    return it;
  endfunction

  function automatic rsa_item_t merge_item(logic [CountW-1:0] cnt, logic signed [63:0] mnz,
                                           logic signed [63:0] mx, logic signed [63:0] sm,
                                           logic signed [63:0] sq);
    rsa_item_t it;
    it = '0;
    it.command = CMD_MERGE;
    it.data.other_count = cnt;
    it.data.other_min_nonzero = mnz;
    it.data.other_max = mx;
    it.data.other_sum = sm;
    it.data.other_sum_squares = sq;
    return it;
  endfunction

  // mostly back to back, sometimes a short pause, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic signed [63:0] pick_value();
    int d;
    d = $urandom_range(0, 4) - 2;
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 64'(int'($urandom_range(0, 2000)) - 1000);
      2: return 64'($signed($urandom));
      // straddle the edges of the 32-bit square range
      3: return ($urandom_range(0, 1) ? SQ_RANGE_MAX : SQ_RANGE_MIN) + d;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(input rsa_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= InTdataW'(it.data);
    s_tuser <= it.command;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // transfer taken at this edge
    pending_totals.push_back(fold_into_totals(it));
    if (it.command == CMD_RECORD) n_records++;
    else n_merges++;
  endtask

  // hold off the sender until every result has come back
  task automatic wait_for_totals();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
  endtask

  // merge bare counts until the 64-bit count lands on target
  task automatic advance_count_to(input logic [63:0] target);
    logic [63:0] need;
    logic [63:0] part;
    need = target - stat_count;
    while (need != 0) begin
      part = (need > MAX63) ? MAX63 : need;
      send_item(merge_item(part[CountW-1:0], 0, INT64_MIN, 0, 0));
      need = need - part;
    end
  endtask

  // first sample is zero: everything loads zero, then a merge may not fill
  // the zero nonzero minimum with a positive value or lower the maximum
  task automatic test_first_sample();
    send_item(record_item(0));
    send_item(merge_item(2, 9, -4, 5, 81));
    send_item(record_item(7));
    send_item(record_item(3));
    send_item(record_item(-2));
  endtask

  task automatic test_merge_rules();
    send_item(merge_item(0, 0, 0, 0, 0));
    send_item(merge_item(4, -10, 100, -300, 12345));
    send_item(merge_item(1, 0, -50, 0, 0));
    send_item(merge_item(MAX63[CountW-1:0], INT64_MAX, INT64_MIN, INT64_MAX, -1));
    send_item(merge_item(3, INT64_MIN, INT64_MAX, INT64_MIN, INT64_MAX));
  endtask

  task automatic test_sample_extremes();
    send_item(record_item(SQ_RANGE_MAX));
    send_item(record_item(SQ_RANGE_MIN));
    send_item(record_item(SQ_RANGE_MAX + 1));
    send_item(record_item(SQ_RANGE_MIN - 1));
    send_item(record_item(-1));
    send_item(record_item(INT64_MAX));
    send_item(record_item(INT64_MIN));
  endtask

  // count wraps through zero: the record that makes it one reloads the
  // minimums and maximum, a merge into a zero count does not arm that
  task automatic test_count_wrap();
    advance_count_to(64'hFFFF_FFFF_FFFF_FFFF);
    send_item(record_item(11));
    send_item(record_item(-3));
    advance_count_to(64'd0);
    send_item(merge_item(2, 6, -20, 40, 400));
    send_item(record_item(0));
    send_item(record_item(25));
  endtask

  task automatic test_random_stream(input int n_items);
    rsa_item_t it;
    logic [63:0] wide;
    for (int i = 0; i < n_items; i++) begin
      steady = (i < 100);
      if (i == n_items / 2) wait_for_totals();
      if ($urandom_range(0, 99) < 80) begin
        it = record_item(pick_value());
      end else begin
        wide = {$urandom, $urandom};
        it = merge_item($urandom_range(0, 3) == 0 ? wide[CountW-1:0]
                                                  : CountW'($urandom_range(0, 50)),
                        $urandom_range(0, 2) == 0 ? 64'sd0 : pick_value(),
                        pick_value(), pick_value(),
                        $urandom_range(0, 1) ? {$urandom, $urandom}
                                             : 64'($urandom_range(0, 100000)));
      end
      send_item(it);
    end
    steady = 1'b0;
  endtask

  // receiver side: random stalls, off during the steady stretch
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (steady) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (r < 70) begin
        m_tready <= 1'b1;
      end else begin
        stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(5, 30);
        m_tready <= 1'b0;
      end
    end
  end

  // result checker: each output transfer against the oldest prediction
  always @(posedge clk) begin
    rsa_result_t want;
    rsa_out_data_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OutDataW-1:0];
      n_checked++;
      if (pending_totals.size() == 0) begin
        report_mismatch("unexpected transfer", got.total_sum, 0);
      end else begin
        want = pending_totals.pop_front();
        if (want.square_skipped) n_skipped++;
        if (got.total_count !== want.data.total_count)
          report_mismatch("total_count", got.total_count, want.data.total_count);
        if (got.total_sum !== want.data.total_sum)
          report_mismatch("total_sum", got.total_sum, want.data.total_sum);
        if (got.total_sum_squares !== want.data.total_sum_squares)
          report_mismatch("total_sum_squares", got.total_sum_squares,
                          want.data.total_sum_squares);
        if (got.least_nonzero !== want.data.least_nonzero)
          report_mismatch("least_nonzero", got.least_nonzero, want.data.least_nonzero);
        if (got.least_value !== want.data.least_value)
          report_mismatch("least_value", got.least_value, want.data.least_value);
        if (got.greatest_value !== want.data.greatest_value)
          report_mismatch("greatest_value", got.greatest_value, want.data.greatest_value);
        if (m_tuser[0] !== want.square_skipped)
          report_mismatch("square_skipped", m_tuser[0], want.square_skipped);
      end
    end
  end

  initial begin
    n_records = 0;
    n_merges = 0;
    steady = 1'b0;
    stat_count = '0;
    stat_sum = '0;
    stat_sumsq = '0;
    stat_min_nz = '0;
    stat_min = '0;
    stat_max = '0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_first_sample();
    test_merge_rules();
    test_sample_extremes();
    test_count_wrap();
    test_random_stream(1000);

    wait_for_totals();
    // input and result registers: wait on past the last result to catch any stray transfer
    repeat (8) @(posedge clk);
    $display("ran %0d records and %0d merges, %0d results checked, %0d mismatches",
             n_records, n_merges, n_checked, errors);
    $display("%0d samples fell outside the square range; count wrapped through zero",
             n_skipped);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
